FILE: hdl/hsb2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsb2rgb_pkg
// Shared constants and types for the HSB to RGB converter.
// ----------------------------------------------------------------------------
package hsb2rgb_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int CHANNEL_W  = 8;
    localparam int ARGB_W     = 32;
    localparam int M_TDATA_W  = 3 * CHANNEL_W + ARGB_W;

    localparam logic [CHANNEL_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHANNEL_W-1:0] CHANNEL_MAX  = 8'hFF;

    // hue sector, one sixth of a turn each
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

endpackage

FILE: hdl/hsb2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsb2rgb_sector
// First stage: clamps saturation and brightness, splits hue*6 into sector
// and fraction.
// ----------------------------------------------------------------------------
module hsb2rgb_sector #(
    parameter int FRACTION_BITS = hsb2rgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [FRACTION_BITS-1:0]     hue,
    input  logic [FRACTION_BITS:0]       sat,
    input  logic [FRACTION_BITS:0]       bri,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hsb2rgb_pkg::sector_t         sector,
    output logic [FRACTION_BITS-1:0]     frac,
    output logic [FRACTION_BITS:0]       s_val,
    output logic [FRACTION_BITS:0]       v_val
);

    localparam int F = FRACTION_BITS;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic                 valid_reg;
    logic                 valid_next;
    hsb2rgb_pkg::sector_t sector_reg;
    logic [F-1:0]         frac_reg;
    logic [F:0]           s_reg;
    logic [F:0]           v_reg;
    logic [F+2:0]         hue6;
    logic [F:0]           s_clamp;
    logic [F:0]           v_clamp;
    logic                 load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        hue6       = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
        s_clamp    = (sat > ONE) ? ONE : sat;
        v_clamp    = (bri > ONE) ? ONE : bri;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sector_reg <= hsb2rgb_pkg::sector_t'(hue6[F+2:F]);
            frac_reg   <= hue6[F-1:0];
            s_reg      <= s_clamp;
            v_reg      <= v_clamp;
        end
    end

    assign out_valid = valid_reg;
    assign sector    = sector_reg;
    assign frac      = frac_reg;
    assign s_val     = s_reg;
    assign v_val     = v_reg;

endmodule

FILE: hdl/hsb2rgb_product.sv
// ----------------------------------------------------------------------------
// hsb2rgb_product
// Two multiply stages: s*f, s*(1-f), p=v(1-s), then q and t.
// ----------------------------------------------------------------------------
module hsb2rgb_product #(
    parameter int FRACTION_BITS = hsb2rgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  hsb2rgb_pkg::sector_t         sector,
    input  logic [FRACTION_BITS-1:0]     frac,
    input  logic [FRACTION_BITS:0]       s_val,
    input  logic [FRACTION_BITS:0]       v_val,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hsb2rgb_pkg::sector_t         sector_out,
    output logic [FRACTION_BITS:0]       v_out,
    output logic [FRACTION_BITS:0]       p_out,
    output logic [FRACTION_BITS:0]       q_out,
    output logic [FRACTION_BITS:0]       t_out
);

    localparam int F = FRACTION_BITS;
    localparam int PW = 2 * F + 2;
    localparam logic [F:0]    ONE  = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0] HALF = {{(F+2){1'b0}}, 1'b1, {(F-1){1'b0}}};

    // stage A
    logic                 a_valid_reg;
    logic                 a_valid_next;
    logic                 a_ready;
    hsb2rgb_pkg::sector_t a_sector_reg;
    logic [F:0]           a_v_reg;
    logic [F:0]           a_p_reg;
    logic [F:0]           a_sf_reg;
    logic [F:0]           a_s1f_reg;
    logic [PW-1:0]        sf_prod;
    logic [PW-1:0]        s1f_prod;
    logic [PW-1:0]        p_prod;

    // stage B
    logic                 b_valid_reg;
    logic                 b_valid_next;
    hsb2rgb_pkg::sector_t b_sector_reg;
    logic [F:0]           b_v_reg;
    logic [F:0]           b_p_reg;
    logic [F:0]           b_q_reg;
    logic [F:0]           b_t_reg;
    logic [PW-1:0]        q_prod;
    logic [PW-1:0]        t_prod;

    assign a_ready  = !a_valid_reg || !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    always_comb begin
        sf_prod      = s_val * {1'b0, frac} + HALF;
        s1f_prod     = s_val * (ONE - {1'b0, frac}) + HALF;
        p_prod       = v_val * (ONE - s_val) + HALF;
        a_valid_next = a_ready ? in_valid : a_valid_reg;
    end

    always_comb begin
        q_prod       = a_v_reg * (ONE - a_sf_reg) + HALF;
        t_prod       = a_v_reg * (ONE - a_s1f_reg) + HALF;
        b_valid_next = (!b_valid_reg || out_ready) ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_sector_reg <= sector;
            a_v_reg      <= v_val;
            a_sf_reg     <= sf_prod[2*F:F];
            a_s1f_reg    <= s1f_prod[2*F:F];
            a_p_reg      <= p_prod[2*F:F];
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && (!b_valid_reg || out_ready)) begin
            b_sector_reg <= a_sector_reg;
            b_v_reg      <= a_v_reg;
            b_p_reg      <= a_p_reg;
            b_q_reg      <= q_prod[2*F:F];
            b_t_reg      <= t_prod[2*F:F];
        end
    end

    assign out_valid  = b_valid_reg;
    assign sector_out = b_sector_reg;
    assign v_out      = b_v_reg;
    assign p_out      = b_p_reg;
    assign q_out      = b_q_reg;
    assign t_out      = b_t_reg;

endmodule

FILE: hdl/hsb2rgb_channel.sv
// ----------------------------------------------------------------------------
// hsb2rgb_channel
// Output stage: scales v, p, q, t to 8 bits and routes them by sector.
// ----------------------------------------------------------------------------
module hsb2rgb_channel #(
    parameter int FRACTION_BITS = hsb2rgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  hsb2rgb_pkg::sector_t                  sector,
    input  logic [FRACTION_BITS:0]                v_val,
    input  logic [FRACTION_BITS:0]                p_val,
    input  logic [FRACTION_BITS:0]                q_val,
    input  logic [FRACTION_BITS:0]                t_val,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hsb2rgb_pkg::CHANNEL_W-1:0]     red,
    output logic [hsb2rgb_pkg::CHANNEL_W-1:0]     green,
    output logic [hsb2rgb_pkg::CHANNEL_W-1:0]     blue
);

    localparam int F  = FRACTION_BITS;
    localparam int CW = hsb2rgb_pkg::CHANNEL_W;
    localparam int SW = F + 9;
    localparam logic [SW-1:0] HALF = {{10{1'b0}}, {(F-1){1'b0}}} | (SW'(1) << (F - 1));

    function automatic logic [CW-1:0] scale(input logic [F:0] x);
        logic [SW-1:0] acc;
        acc = ({x, 8'b0} - {8'b0, x}) + HALF;
        scale = (acc[SW-1:F] > {1'b0, hsb2rgb_pkg::CHANNEL_MAX}) ?
                hsb2rgb_pkg::CHANNEL_MAX : acc[F+CW-1:F];
    endfunction

    logic          valid_reg;
    logic          valid_next;
    logic [CW-1:0] red_reg;
    logic [CW-1:0] green_reg;
    logic [CW-1:0] blue_reg;
    logic [CW-1:0] red_next;
    logic [CW-1:0] green_next;
    logic [CW-1:0] blue_next;
    logic [CW-1:0] cv;
    logic [CW-1:0] cp;
    logic [CW-1:0] cq;
    logic [CW-1:0] ct;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        cv = scale(v_val);
        cp = scale(p_val);
        cq = scale(q_val);
        ct = scale(t_val);
        unique case (sector)
            hsb2rgb_pkg::SEC_RY: begin
                red_next = cv; green_next = ct; blue_next = cp;
            end
            hsb2rgb_pkg::SEC_YG: begin
                red_next = cq; green_next = cv; blue_next = cp;
            end
            hsb2rgb_pkg::SEC_GC: begin
                red_next = cp; green_next = cv; blue_next = ct;
            end
            hsb2rgb_pkg::SEC_CB: begin
                red_next = cp; green_next = cq; blue_next = cv;
            end
            hsb2rgb_pkg::SEC_BM: begin
                red_next = ct; green_next = cp; blue_next = cv;
            end
            default: begin
                red_next = cv; green_next = cp; blue_next = cq;
            end
        endcase
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

FILE: hdl/hsb_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// hsb_to_rgb_converter_core
// HSB to 8-bit RGB and opaque ARGB converter, fixed point, stream interface.
// ----------------------------------------------------------------------------
// Takes one request per clock unless a stall on m_tready backs up, and returns
// one result per request. The work runs in four register stages: hue split
// and clamping, the first multiplier bank (s*f, s*(1-f), v(1-s)), the second
// multiplier bank (q, t), and channel scaling with sector routing. Each stage
// holds its own valid bit and takes a new request whenever it is empty or its
// successor moves, so bubbles close up and a stall on m_tready loses nothing.
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter_core #(
    parameter int FRACTION_BITS = hsb2rgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // hue_fraction, saturation, brightness, zero pad
    input  logic [((3*FRACTION_BITS+2+7)/8)*8-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // red, green, blue, argb_word
    output logic [hsb2rgb_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int F  = FRACTION_BITS;
    localparam int CW = hsb2rgb_pkg::CHANNEL_W;

    logic                 st1_valid;
    logic                 st1_ready;
    hsb2rgb_pkg::sector_t st1_sector;
    logic [F-1:0]         st1_frac;
    logic [F:0]           st1_s;
    logic [F:0]           st1_v;

    logic                 st2_valid;
    logic                 st2_ready;
    hsb2rgb_pkg::sector_t st2_sector;
    logic [F:0]           st2_v;
    logic [F:0]           st2_p;
    logic [F:0]           st2_q;
    logic [F:0]           st2_t;

    logic [CW-1:0]        red;
    logic [CW-1:0]        green;
    logic [CW-1:0]        blue;

    hsb2rgb_sector #(
        .FRACTION_BITS(F)
    ) u_sector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .hue       (s_tdata[F-1:0]),
        .sat       (s_tdata[2*F:F]),
        .bri       (s_tdata[3*F+1:2*F+1]),
        .out_valid (st1_valid),
        .out_ready (st1_ready),
        .sector    (st1_sector),
        .frac      (st1_frac),
        .s_val     (st1_s),
        .v_val     (st1_v)
    );

    hsb2rgb_product #(
        .FRACTION_BITS(F)
    ) u_product (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (st1_valid),
        .in_ready   (st1_ready),
        .sector     (st1_sector),
        .frac       (st1_frac),
        .s_val      (st1_s),
        .v_val      (st1_v),
        .out_valid  (st2_valid),
        .out_ready  (st2_ready),
        .sector_out (st2_sector),
        .v_out      (st2_v),
        .p_out      (st2_p),
        .q_out      (st2_q),
        .t_out      (st2_t)
    );

    hsb2rgb_channel #(
        .FRACTION_BITS(F)
    ) u_channel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st2_valid),
        .in_ready  (st2_ready),
        .sector    (st2_sector),
        .v_val     (st2_v),
        .p_val     (st2_p),
        .q_val     (st2_q),
        .t_val     (st2_t),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {hsb2rgb_pkg::ALPHA_OPAQUE, red, green, blue, blue, green, red};

endmodule
